[rtl/cdht_pkg.sv]
// Package for the countdown hold timer: phase and event codes, field widths
// and the reciprocal constants used by the time split pipeline.
// No dependencies.
`default_nettype none

package cdht_pkg;

  localparam int TIME_BITS = 48;
  localparam int REM_BITS  = TIME_BITS + 1;

  // Phase codes.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_COUNT  = 3'd1;
  localparam logic [2:0] PH_HOLD   = 3'd2;
  localparam logic [2:0] PH_LAUNCH = 3'd3;
  localparam logic [2:0] PH_ABORT  = 3'd4;

  // Event codes.
  localparam logic [2:0] K_ARM    = 3'd0;
  localparam logic [2:0] K_HOLD   = 3'd1;
  localparam logic [2:0] K_RESUME = 3'd2;
  localparam logic [2:0] K_ABORT  = 3'd3;
  localparam logic [2:0] K_TICK   = 3'd4;

  // Hours: (mag >> 7) / 28125, since 3600000 = 2^7 * 28125.
  localparam logic [14:0] HR_DIV   = 15'd28125;
  localparam logic [15:0] HR_DIV2  = 16'd56250;
  localparam logic [25:0] HR_RECIP = 26'd39093746;   // floor(2^40 / 28125)
  // Minutes: (rem >> 5) / 1875, exact with a 28-bit reciprocal.
  localparam logic [17:0] MIN_RECIP = 18'd143166;    // ceil(2^28 / 1875)
  localparam logic [15:0] MS_PER_MIN = 16'd60000;
  // Seconds: (rem2 >> 3) / 125, exact with a 20-bit reciprocal.
  localparam logic [13:0] SEC_RECIP = 14'd8389;      // ceil(2^20 / 125)

  typedef struct packed {
    logic                      accepted;
    logic [2:0]                phase;
    logic signed [REM_BITS-1:0] remaining_ms;
    logic                      before_launch;
    logic [16:0]               hours;
    logic [5:0]                minutes;
    logic [5:0]                seconds;
    logic [TIME_BITS-1:0]      hold_sum_ms;
  } result_t;

endpackage

`default_nettype wire

[rtl/countdown_hold_timer.sv]
// Countdown hold timer top level: event state update and the pipeline that
// splits the remaining time into hours, minutes and seconds.
// Depends on cdht_pkg.
`default_nettype none

// Channel  Dir  Fields
// s_*      in   tuser: kind[2:0]; tdata: time_ms[47:0], launch_target_ms[95:48]
// m_*      out  tdata: accepted[0], phase[3:1], remaining_ms[52:4],
//               before_launch[53], hours[70:54], minutes[76:71],
//               seconds[82:77], hold_sum_ms[130:83]
//
// The timer state is updated in the cycle a word is accepted, so one event
// can enter every cycle while the pipeline is not stalled. Its result passes
// through the reciprocal multiply and correction stages of the hours, minutes
// and seconds split. Each stage holds its word while the next one is full,
// so bubbles close up under a stalled output. Reset clears the phase, the
// timer registers and all stage valid flags.

module countdown_hold_timer
  import cdht_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [95:0]  s_tdata,   // time_ms, launch_target_ms
  input  wire logic [2:0]   s_tuser,   // kind
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata    // see table above, zero filled above bit 130
);

  localparam int NSTG = 10;

  // Timer state.
  logic [2:0]           phase_reg, phase_next;
  logic [TIME_BITS-1:0] target_time, target_next;
  logic [TIME_BITS-1:0] hold_begin, hold_begin_next;
  logic [TIME_BITS-1:0] hold_accum, hold_accum_next;

  logic [TIME_BITS-1:0] now, tgt, hold_len, ref_time, mag;
  logic [TIME_BITS:0]   tgt_sum, acc_sum;
  logic                 acc, neg, take;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;
  result_t         pay [NSTG];
  result_t         pay5_next, pay7_next, pay9_next;

  // Working fields of the split pipeline.
  logic [40:0] x1, x2, x3, x4;
  logic [6:0]  lo1, lo2, lo3, lo4, lo5;
  logic [50:0] pp_hi2;
  logic [41:0] pp_lo2;
  logic [66:0] pp_sum;
  logic [16:0] qe3, qe4, qe5;
  logic [31:0] pq4;
  logic [40:0] r_full;
  logic [16:0] r5;
  logic [21:0] rem6, rem7, rem8;
  logic [14:0] r0;
  logic [16:0] hours_fix;
  logic [34:0] prod7;
  logic [5:0]  min8;
  logic [21:0] p8;
  logic [21:0] rem2_full;
  logic [26:0] prod9;

  assign now  = s_tdata[47:0];
  assign tgt  = s_tdata[95:48];
  assign take = s_tvalid && s_tready;

  // Event decode and next state.
  always_comb begin
    phase_next      = phase_reg;
    target_next     = target_time;
    hold_begin_next = hold_begin;
    hold_accum_next = hold_accum;
    acc             = 1'b0;
    hold_len        = (now >= hold_begin) ? now - hold_begin : '0;
    tgt_sum         = {1'b0, target_time} + {1'b0, hold_len};
    acc_sum         = {1'b0, hold_accum} + {1'b0, hold_len};
    unique case (s_tuser)
      K_ARM: begin
        if (tgt > now) begin
          phase_next      = PH_COUNT;
          target_next     = tgt;
          hold_begin_next = '0;
          hold_accum_next = '0;
          acc             = 1'b1;
        end
      end
      K_HOLD: begin
        if (phase_reg == PH_COUNT) begin
          phase_next      = PH_HOLD;
          hold_begin_next = now;
          acc             = 1'b1;
        end
      end
      K_RESUME: begin
        if (phase_reg == PH_HOLD) begin
          target_next     = tgt_sum[TIME_BITS] ? '1 : tgt_sum[TIME_BITS-1:0];
          hold_accum_next = acc_sum[TIME_BITS] ? '1 : acc_sum[TIME_BITS-1:0];
          phase_next      = PH_COUNT;
          acc             = 1'b1;
        end
      end
      K_ABORT: begin
        phase_next = PH_ABORT;
        acc        = 1'b1;
      end
      K_TICK: begin
        if (phase_reg == PH_COUNT && now >= target_time) begin
          phase_next = PH_LAUNCH;
        end
        acc = 1'b1;
      end
      default: begin
      end
    endcase

    // Signed distance to the target, frozen at the hold start while held.
    ref_time = (phase_next == PH_HOLD) ? hold_begin_next : now;
    mag      = '0;
    neg      = 1'b0;
    if (phase_next != PH_IDLE && phase_next != PH_ABORT) begin
      if (target_next >= ref_time) begin
        mag = target_next - ref_time;
      end else begin
        mag = ref_time - target_next;
        neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg   <= PH_IDLE;
      target_time <= '0;
      hold_begin  <= '0;
      hold_accum  <= '0;
    end else if (take) begin
      phase_reg   <= phase_next;
      target_time <= target_next;
      hold_begin  <= hold_begin_next;
      hold_accum  <= hold_accum_next;
    end
  end

  // A stage loads when it is empty or its word moves on.
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Stage 1: result word after the state update.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pay[0].accepted      <= acc;
      pay[0].phase         <= phase_next;
      pay[0].remaining_ms  <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      pay[0].before_launch <= !neg;
      pay[0].hours         <= '0;
      pay[0].minutes       <= '0;
      pay[0].seconds       <= '0;
      pay[0].hold_sum_ms   <= hold_accum_next;
      x1                   <= mag[47:7];
      lo1                  <= mag[6:0];
    end
  end

  // Stage 2: partial products of the hours reciprocal.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pay[1] <= pay[0];
      pp_hi2 <= 51'(x1[40:16]) * 51'(HR_RECIP);
      pp_lo2 <= 42'(x1[15:0]) * 42'(HR_RECIP);
      x2     <= x1;
      lo2    <= lo1;
    end
  end

  // Stage 3: quotient estimate, at most two below the true hours.
  assign pp_sum = {pp_hi2, 16'd0} + 67'(pp_lo2);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pay[2] <= pay[1];
      qe3    <= pp_sum[56:40];
      x3     <= x2;
      lo3    <= lo2;
    end
  end

  // Stage 4: estimate times the divisor.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      pay[3] <= pay[2];
      pq4    <= 32'(qe3) * 32'(HR_DIV);
      qe4    <= qe3;
      x4     <= x3;
      lo4    <= lo3;
    end
  end

  // Stage 5: remainder of the estimate, below three divisors.
  assign r_full = x4 - 41'(pq4);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pay[4] <= pay[3];
      r5     <= r_full[16:0];
      qe5    <= qe4;
      lo5    <= lo4;
    end
  end

  // Stage 6: correct the estimate and rebuild the millisecond remainder.
  always_comb begin
    if (r5 >= 17'(HR_DIV2)) begin
      hours_fix = qe5 + 17'd2;
      r0        = 15'(r5 - 17'(HR_DIV2));
    end else if (r5 >= 17'(HR_DIV)) begin
      hours_fix = qe5 + 17'd1;
      r0        = 15'(r5 - 17'(HR_DIV));
    end else begin
      hours_fix = qe5;
      r0        = r5[14:0];
    end
    pay5_next       = pay[4];
    pay5_next.hours = hours_fix;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      pay[5] <= pay5_next;
      rem6   <= {r0, lo5};
    end
  end

  // Stage 7: minutes reciprocal product.
  always_ff @(posedge clk) begin
    if (en[6]) begin
      pay[6] <= pay[5];
      prod7  <= 35'(rem6[21:5]) * 35'(MIN_RECIP);
      rem7   <= rem6;
    end
  end

  // Stage 8: minutes and their milliseconds.
  always_comb begin
    pay7_next         = pay[6];
    pay7_next.minutes = prod7[33:28];
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      pay[7] <= pay7_next;
      min8   <= prod7[33:28];
      p8     <= 22'(prod7[33:28]) * 22'(MS_PER_MIN);
      rem8   <= rem7;
    end
  end

  // Stage 9: milliseconds within the minute, then the seconds product.
  assign rem2_full = rem8 - p8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      pay[8] <= pay[7];
      prod9  <= 27'(rem2_full[15:3]) * 27'(SEC_RECIP);
    end
  end

  // Stage 10: output register.
  always_comb begin
    pay9_next         = pay[8];
    pay9_next.seconds = prod9[25:20];
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      pay[9] <= pay9_next;
    end
  end

  assign m_tvalid = vld[NSTG-1];
  assign m_tdata  = {5'd0,
                     pay[9].hold_sum_ms,
                     pay[9].seconds,
                     pay[9].minutes,
                     pay[9].hours,
                     pay[9].before_launch,
                     pay[9].remaining_ms,
                     pay[9].phase,
                     pay[9].accepted};

  // An accepted arm starts a fresh countdown with no hold time.
  assert property (@(posedge clk) disable iff (rst)
    (take && s_tuser == K_ARM && tgt > now) |=>
      (phase_reg == PH_COUNT && hold_accum == '0 && hold_begin == '0))
    else $error("arm did not start a fresh countdown");

  // Idle is only left by an arm or an abort, so the timer registers stay at reset.
  assert property (@(posedge clk) disable iff (rst)
    (phase_reg == PH_IDLE) |->
      (target_time == '0 && hold_begin == '0 && hold_accum == '0))
    else $error("timer registers changed while idle");

  // The reciprocal split must give in-range minutes and seconds.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (pay[9].minutes < 6'd60 && pay[9].seconds < 6'd60))
    else $error("minutes or seconds out of range");

  // Stage 8 keeps the minutes it multiplied.
  assert property (@(posedge clk) disable iff (rst)
    vld[7] |-> (p8 == 22'(min8) * 22'(MS_PER_MIN)))
    else $error("minute product does not match minutes");

endmodule

`default_nettype wire
